// ----- hw/rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: decode state type, end codes,
// the result bundle passed from decode to output buffer, and helpers.
// No dependencies.
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    localparam logic [1:0] END_DATA  = 2'd0;
    localparam logic [1:0] END_QUOTE = 2'd1;
    localparam logic [1:0] END_NUL   = 2'd2;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    localparam logic [1:0] HEX_LAST = 2'd3;

    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } bundle_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
// Escape decoder: holds the escape state and turns one raw byte into a
// bundle of zero to three result bytes. Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire logic [7:0]      in_byte,
    output jsu_pkg::bundle_t     bundle
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_count_reg, hex_count_next;
    logic [15:0]    code_reg, code_next;
    logic           stopped_reg, stopped_next;

    logic [4:0]     hd;
    logic [15:0]    code_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= jsu_pkg::MODE_NORMAL;
            hex_count_reg <= 2'd0;
            code_reg      <= 16'd0;
            stopped_reg   <= 1'b0;
        end
        else if (load)
        begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            code_reg      <= code_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_comb
    begin
        hd             = jsu_pkg::hex_digit(in_byte);
        code_upd       = (!stopped_reg && hd[4]) ? {code_reg[11:0], hd[3:0]} : code_reg;
        mode_next      = jsu_pkg::MODE_NORMAL;
        hex_count_next = 2'd0;
        code_next      = 16'd0;
        stopped_next   = 1'b0;
        bundle         = '0;
        bundle.kind    = jsu_pkg::END_DATA;

        if (in_byte == jsu_pkg::CHAR_NUL)
        begin
            bundle.cnt  = 2'd1;
            bundle.kind = jsu_pkg::END_NUL;
        end
        else
        begin
            case (mode_reg)
                jsu_pkg::MODE_ESCAPE:
                begin
                    bundle.cnt   = 2'd1;
                    bundle.byte0 = in_byte;
                    case (in_byte)
                        jsu_pkg::CHAR_QUOTE,
                        jsu_pkg::CHAR_BACKSLASH,
                        jsu_pkg::CHAR_SLASH: bundle.byte0 = in_byte;
                        jsu_pkg::CHAR_B:     bundle.byte0 = 8'h08;
                        jsu_pkg::CHAR_F:     bundle.byte0 = 8'h0C;
                        jsu_pkg::CHAR_N:     bundle.byte0 = 8'h0A;
                        jsu_pkg::CHAR_R:     bundle.byte0 = 8'h0D;
                        jsu_pkg::CHAR_T:     bundle.byte0 = 8'h09;
                        jsu_pkg::CHAR_U:
                        begin
                            bundle.cnt = 2'd0;
                            mode_next  = jsu_pkg::MODE_HEX;
                        end
                        default:
                        begin
                            bundle.cnt   = 2'd2;
                            bundle.byte0 = jsu_pkg::CHAR_BACKSLASH;
                            bundle.byte1 = in_byte;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX:
                begin
                    if (hex_count_reg != jsu_pkg::HEX_LAST)
                    begin
                        mode_next      = jsu_pkg::MODE_HEX;
                        hex_count_next = hex_count_reg + 2'd1;
                        code_next      = code_upd;
                        stopped_next   = stopped_reg | ~hd[4];
                    end
                    else if (code_upd < 16'h0080)
                    begin
                        bundle.cnt   = 2'd1;
                        bundle.byte0 = code_upd[7:0];
                    end
                    else if (code_upd < 16'h0800)
                    begin
                        bundle.cnt   = 2'd2;
                        bundle.byte0 = {3'b110, code_upd[10:6]};
                        bundle.byte1 = {2'b10, code_upd[5:0]};
                    end
                    else
                    begin
                        bundle.cnt   = 2'd3;
                        bundle.byte0 = {4'b1110, code_upd[15:12]};
                        bundle.byte1 = {2'b10, code_upd[11:6]};
                        bundle.byte2 = {2'b10, code_upd[5:0]};
                    end
                end
                default:
                begin
                    if (in_byte == jsu_pkg::CHAR_QUOTE)
                    begin
                        bundle.cnt  = 2'd1;
                        bundle.kind = jsu_pkg::END_QUOTE;
                    end
                    else if (in_byte == jsu_pkg::CHAR_BACKSLASH)
                    begin
                        mode_next = jsu_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        bundle.cnt   = 2'd1;
                        bundle.byte0 = in_byte;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_out_buf.sv -----
// Result register: holds one decoded bundle and hands its bytes out one
// transaction per cycle while m_tready is high. Depends on jsu_pkg.
`default_nettype none

module jsu_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire jsu_pkg::bundle_t bundle,
    output logic                  free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,  // out_byte
    output logic [1:0]            m_tuser,  // end_kind
    output logic                  m_tlast
);

    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic [7:0] b2_reg, b2_next;
    logic       pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = b0_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = (cnt_reg == 2'd1);
    assign pop      = m_tvalid && m_tready;
    assign free     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        b2_next   = b2_reg;
        if (load)
        begin
            cnt_next  = bundle.cnt;
            kind_next = bundle.kind;
            b0_next   = bundle.byte0;
            b1_next   = bundle.byte1;
            b2_next   = bundle.byte2;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            kind_next = jsu_pkg::END_DATA;
            b0_next   = b1_reg;
            b1_next   = b2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            kind_reg <= jsu_pkg::END_DATA;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_top.sv -----
// Flow: an accepted byte is held in in_byte_reg, then decoded and loaded into the
// output register when free. Throughput: one input byte per cycle while not stalled;
// a byte with several results (3-byte UTF-8) holds the output until all are taken.
// Reset: rst_n clears the escape state and both stages, leaving the block idle.
// Top level of the JSON string unescaper; uses jsu_pkg, jsu_decode and jsu_out_buf.
`default_nettype none

module json_string_unescape_utf8_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [1:0]      m_tuser,   // end_kind
    output logic            m_tlast
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             free;
    logic             load;
    jsu_pkg::bundle_t bundle;

    assign load     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .in_byte (in_byte_reg),
        .bundle  (bundle)
    );

    jsu_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .bundle   (bundle),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
